[hw/rtl/mstt_pkg.sv]
package mstt_pkg;

  localparam int NumTimersDefault = 16;
  localparam int HandleLimit      = 16;
  localparam int FireLimit        = 16;

  typedef enum logic [2:0] {
    REQ_CREATE     = 3'd0,
    REQ_START_ONCE = 3'd1,
    REQ_START_PER  = 3'd2,
    REQ_RESTART    = 3'd3,
    REQ_STOP       = 3'd4,
    REQ_DELETE     = 3'd5,
    REQ_IS_ACTIVE  = 3'd6,
    REQ_POLL       = 3'd7
  } req_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_NO_MEM  = 2'd2
  } status_t;

  // One request as it leaves the front end.
  typedef struct packed {
    req_t        req;
    logic [3:0]  slot;
    logic [63:0] now_us;
    logic [63:0] duration_us;
    logic [4:0]  fire_cap;
  } cmd_t;

  // One result item.
  typedef struct packed {
    status_t    status;
    logic [3:0] handle;
    logic       fired;
    logic       is_running;
    logic [4:0] fire_count;
    logic       last;
  } res_t;

endpackage

[hw/rtl/mstt_ram.sv]
module mstt_ram #(
  parameter int Width = 64,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  // One write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/mstt_front.sv]
module mstt_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  mstt_pkg::cmd_t in_cmd,
  output logic           q_valid,
  input  logic           q_pop,
  output mstt_pkg::cmd_t q_cmd
);
  import mstt_pkg::*;

  // Two-entry request queue between the stream input and the engine.
  cmd_t       buf_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push;

  assign in_tready = (cnt_r != 2'd2);
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (cnt_r != 2'd0);
  assign q_cmd     = buf_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wp_r] <= in_cmd;
    end
  end

endmodule

[hw/rtl/mstt_engine.sv]
module mstt_engine #(
  parameter int NUM_TIMERS = mstt_pkg::NumTimersDefault
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  output logic           q_pop,
  input  mstt_pkg::cmd_t q_cmd,
  output logic           out_tvalid,
  input  logic           out_tready,
  output mstt_pkg::res_t out_res
);
  import mstt_pkg::*;

  localparam int Usable = (NUM_TIMERS < HandleLimit) ? NUM_TIMERS : HandleLimit;
  localparam int IdxW   = (Usable > 1) ? $clog2(Usable) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(Usable - 1);

  typedef enum logic [2:0] {S_IDLE, S_EXEC, S_READ, S_SCAN, S_FIN} state_t;

  state_t            state_r, state_nxt;
  cmd_t              cmd_r, cmd_nxt;
  logic [Usable-1:0] alloc_r, alloc_nxt, act_r, act_nxt, per_r, per_nxt;
  logic [IdxW-1:0]   idx_r, idx_nxt;
  logic [IdxW-1:0]   pend_r, pend_nxt;
  logic [4:0]        cnt_r, cnt_nxt;
  logic [4:0]        lim_r, lim_nxt;
  logic              res_v_r, res_v_nxt;
  res_t              res_r, res_nxt;

  // Period and expiry stores.
  logic             p_we, e_we;
  logic [IdxW-1:0]  p_wa, e_wa, p_ra, e_ra;
  logic [63:0]      p_wd, e_wd, p_rd, e_rd;

  mstt_ram #(.Width(64), .Depth(1 << IdxW)) u_period (
    .clk, .we(p_we), .waddr(p_wa), .wdata(p_wd), .raddr(p_ra), .rdata(p_rd));
  mstt_ram #(.Width(64), .Depth(1 << IdxW)) u_expiry (
    .clk, .we(e_we), .waddr(e_wa), .wdata(e_wd), .raddr(e_ra), .rdata(e_rd));

  logic             in_rng, valid_s;
  logic [IdxW-1:0]  s_idx;
  logic             free_any;
  logic [IdxW-1:0]  free_idx;
  logic             due;
  logic             zero_dur;
  logic             out_free;
  logic [63:0]      sum_now_dur;

  function automatic res_t fire_res(logic [IdxW-1:0] h, logic [4:0] n, logic l);
    res_t r;
    r.status     = ST_OK;
    r.handle     = 4'(h);
    r.fired      = 1'b1;
    r.is_running = 1'b0;
    r.fire_count = n;
    r.last       = l;
    return r;
  endfunction

  assign in_rng      = ({1'b0, cmd_r.slot} < 5'(Usable));
  assign s_idx       = cmd_r.slot[IdxW-1:0];
  assign valid_s     = in_rng && alloc_r[s_idx];
  assign zero_dur    = (cmd_r.duration_us == 64'd0);
  assign sum_now_dur = cmd_r.now_us + cmd_r.duration_us;
  assign due         = alloc_r[idx_r] && act_r[idx_r] && !(cmd_r.now_us < e_rd);

  // Lowest free slot.
  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = Usable - 1; i >= 0; i--) begin
      if (!alloc_r[i]) begin
        free_any = 1'b1;
        free_idx = IdxW'(i);
      end
    end
  end

  assign out_free   = !res_v_r || out_tready;
  assign q_pop      = (state_r == S_IDLE) && q_valid;
  assign out_tvalid = res_v_r;
  assign out_res    = res_r;

  // Both stores are read at the slot the scan looks at in the next cycle.
  assign p_ra = idx_nxt;
  assign e_ra = idx_nxt;

  // Request sequencer. A poll checks one slot per cycle unless a held firing
  // waits to leave; a firing is held in pend_r until the next firing or the
  // end of the scan shows whether it is the last result of the poll.
  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    alloc_nxt = alloc_r;
    act_nxt   = act_r;
    per_nxt   = per_r;
    idx_nxt   = idx_r;
    pend_nxt  = pend_r;
    cnt_nxt   = cnt_r;
    lim_nxt   = lim_r;
    res_v_nxt = res_v_r && !out_tready;
    res_nxt   = res_r;
    p_we = 1'b0; p_wa = s_idx; p_wd = cmd_r.duration_us;
    e_we = 1'b0; e_wa = s_idx; e_wd = sum_now_dur;
    unique case (state_r)
      S_IDLE: begin
        if (q_pop) begin
          cmd_nxt = q_cmd;
          idx_nxt = '0;
          cnt_nxt = '0;
          lim_nxt = (q_cmd.fire_cap > 5'(FireLimit)) ? 5'(FireLimit) : q_cmd.fire_cap;
          if (q_cmd.req == REQ_POLL) begin
            state_nxt = (q_cmd.fire_cap == 5'd0) ? S_FIN : S_READ;
          end else begin
            state_nxt = S_EXEC;
          end
        end
      end
      S_READ: begin
        // Slot 0 is being read; its data is ready in the first scan cycle.
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (due) begin
          // A held firing must leave before the new one takes its place.
          if (cnt_r == 5'd0 || out_free) begin
            if (cnt_r != 5'd0) begin
              res_v_nxt = 1'b1;
              res_nxt   = fire_res(pend_r, cnt_r, 1'b0);
            end
            if (per_r[idx_r]) begin
              e_we = 1'b1;
              e_wa = idx_r;
              e_wd = cmd_r.now_us + p_rd;
            end else begin
              act_nxt[idx_r] = 1'b0;
            end
            pend_nxt = idx_r;
            cnt_nxt  = cnt_r + 5'd1;
            if (cnt_r + 5'd1 == lim_r || idx_r == LastIdx) begin
              state_nxt = S_FIN;
            end else begin
              idx_nxt = idx_r + IdxW'(1);
            end
          end
        end else if (idx_r == LastIdx) begin
          state_nxt = S_FIN;
        end else begin
          idx_nxt = idx_r + IdxW'(1);
        end
      end
      S_FIN: begin
        if (out_free) begin
          res_v_nxt = 1'b1;
          state_nxt = S_IDLE;
          if (cnt_r != 5'd0) begin
            res_nxt = fire_res(pend_r, cnt_r, 1'b1);
          end else begin
            res_nxt = '{status: ST_OK, handle: 4'd0, fired: 1'b0,
                        is_running: 1'b0, fire_count: 5'd0, last: 1'b1};
          end
        end
      end
      S_EXEC: begin
        if (out_free) begin
          res_v_nxt = 1'b1;
          state_nxt = S_IDLE;
          res_nxt   = '{status: ST_OK, handle: 4'd0, fired: 1'b0,
                        is_running: 1'b0, fire_count: 5'd0, last: 1'b1};
          if (cmd_r.req == REQ_CREATE) begin
            if (free_any) begin
              alloc_nxt[free_idx] = 1'b1;
              act_nxt[free_idx]   = 1'b0;
              per_nxt[free_idx]   = 1'b0;
              res_nxt.handle      = 4'(free_idx);
            end else begin
              res_nxt.status = ST_NO_MEM;
            end
          end else if (!valid_s) begin
            res_nxt.status = ST_INVALID;
          end else begin
            unique case (cmd_r.req)
              REQ_START_ONCE, REQ_RESTART: begin
                p_we = 1'b1;
                e_we = 1'b1;
                per_nxt[s_idx] = 1'b0;
                // A one-shot start with no delay fires right away.
                if (cmd_r.req == REQ_START_ONCE && zero_dur) begin
                  act_nxt[s_idx]     = 1'b0;
                  res_nxt.handle     = cmd_r.slot;
                  res_nxt.fired      = 1'b1;
                  res_nxt.fire_count = 5'd1;
                end else begin
                  act_nxt[s_idx] = 1'b1;
                end
              end
              REQ_START_PER: begin
                if (zero_dur) begin
                  res_nxt.status = ST_INVALID;
                end else begin
                  p_we = 1'b1;
                  e_we = 1'b1;
                  per_nxt[s_idx] = 1'b1;
                  act_nxt[s_idx] = 1'b1;
                end
              end
              REQ_STOP: act_nxt[s_idx] = 1'b0;
              REQ_DELETE: begin
                alloc_nxt[s_idx] = 1'b0;
                act_nxt[s_idx]   = 1'b0;
                per_nxt[s_idx]   = 1'b0;
              end
              REQ_IS_ACTIVE: res_nxt.is_running = act_r[s_idx];
              default: ;
            endcase
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cmd_r   <= '0;
      alloc_r <= '0;
      act_r   <= '0;
      per_r   <= '0;
      idx_r   <= '0;
      pend_r  <= '0;
      cnt_r   <= '0;
      lim_r   <= '0;
      res_v_r <= 1'b0;
      res_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cmd_r   <= cmd_nxt;
      alloc_r <= alloc_nxt;
      act_r   <= act_nxt;
      per_r   <= per_nxt;
      idx_r   <= idx_nxt;
      pend_r  <= pend_nxt;
      cnt_r   <= cnt_nxt;
      lim_r   <= lim_nxt;
      res_v_r <= res_v_nxt;
      res_r   <= res_nxt;
    end
  end

endmodule

[hw/rtl/multi_slot_timer_table.sv]
// Timer slot table with a stream request port and a stream result port; the
// request code travels in in_tuser. Create, start, restart, stop, delete and
// is_active give one result, registered behind the request queue and the
// engine's command register, and the engine takes a new request only once
// it is back in its idle state. A poll scans the usable slots (NUM_TIMERS,
// at most 16) in index order, one per cycle, and gives one result per timer
// that fires, flagged by out_tuser, or a single empty result; its last
// result carries tlast and the final fire count, and the fire limit can end
// the scan early. A firing is held until the next firing or the end of the
// scan shows whether it is the last, so result-side stalls pause the scan
// only while a held result waits to leave. A two-entry queue takes requests
// while the engine is busy.
module multi_slot_timer_table #(
  parameter int NUM_TIMERS = mstt_pkg::NumTimersDefault
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // tdata: slot[3:0], now_us[67:4], duration_us[131:68], fire_cap[136:132],
  //        zero fill
  input  logic [143:0] in_tdata,
  // tuser: req_type[2:0]
  input  logic [2:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // tdata: status[1:0], handle[5:2], is_running[6], fire_count[11:7],
  //        zero fill
  output logic [15:0]  out_tdata,
  // tuser: fired
  output logic         out_tuser,
  output logic         out_tlast
);
  import mstt_pkg::*;

  cmd_t in_cmd, q_cmd;
  res_t res;
  logic q_valid, q_pop;

  assign in_cmd = '{req: req_t'(in_tuser), slot: in_tdata[3:0],
                    now_us: in_tdata[67:4], duration_us: in_tdata[131:68],
                    fire_cap: in_tdata[136:132]};

  mstt_front u_front (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_cmd,
    .q_valid, .q_pop, .q_cmd);

  mstt_engine #(.NUM_TIMERS(NUM_TIMERS)) u_engine (
    .clk, .rst_n, .q_valid, .q_pop, .q_cmd,
    .out_tvalid, .out_tready, .out_res(res));

  assign out_tdata = {4'd0, res.fire_count, res.is_running, res.handle, res.status};
  assign out_tuser = res.fired;
  assign out_tlast = res.last;

endmodule

[sim/tb.sv]
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mstt_pkg::*;

  localparam int NSLOTS = 16;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  // tdata: slot, now_us, duration_us, fire_cap, zero fill
  logic [143:0] in_tdata;
  // tuser: req_type
  logic [2:0]   in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  // tdata: status, handle, is_running, fire_count, zero fill
  logic [15:0]  out_tdata;
  // tuser: fired
  logic         out_tuser;
  logic         out_tlast;

  multi_slot_timer_table #(.NUM_TIMERS(NSLOTS)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  // Shadow copy of the timer table.
  logic        tbl_alloc [NSLOTS];
  logic        tbl_active[NSLOTS];
  logic        tbl_per   [NSLOTS];
  logic [63:0] tbl_period[NSLOTS];
  logic [63:0] tbl_expiry[NSLOTS];

  res_t pending_results[$];
  int   errors = 0;
  logic done_sending = 0;

  function automatic res_t mk_res(status_t st, logic [3:0] h, logic f, logic r,
                                  logic [4:0] c, logic l);
    res_t x;
    x.status = st; x.handle = h; x.fired = f; x.is_running = r;
    x.fire_count = c; x.last = l;
    return x;
  endfunction

  // Apply one request to the shadow table and queue the results it causes.
  task automatic predict_timer_request(cmd_t c);
    int lim;
    int cnt;
    logic ok;
    res_t r;
    ok = tbl_alloc[c.slot];
    case (c.req)
      REQ_CREATE: begin
        for (int i = 0; i < NSLOTS; i++) begin
          if (!tbl_alloc[i]) begin
            tbl_alloc[i] = 1; tbl_active[i] = 0; tbl_per[i] = 0;
            pending_results.push_back(mk_res(ST_OK, 4'(i), 0, 0, 0, 1));
            return;
          end
        end
        pending_results.push_back(mk_res(ST_NO_MEM, 0, 0, 0, 0, 1));
      end
      REQ_POLL: begin
        lim = (c.fire_cap > FireLimit) ? FireLimit : c.fire_cap;
        cnt = 0;
        for (int i = 0; i < NSLOTS && cnt < lim; i++) begin
          if (!tbl_alloc[i] || !tbl_active[i] || c.now_us < tbl_expiry[i]) continue;
          if (tbl_per[i]) tbl_expiry[i] = c.now_us + tbl_period[i];
          else tbl_active[i] = 0;
          cnt++;
          pending_results.push_back(mk_res(ST_OK, 4'(i), 1, 0, 5'(cnt), 0));
        end
        if (cnt == 0) begin
          pending_results.push_back(mk_res(ST_OK, 0, 0, 0, 0, 1));
        end else begin
          r = pending_results.pop_back();
          r.last = 1;
          pending_results.push_back(r);
        end
      end
      default: begin
        if (!ok) begin
          pending_results.push_back(mk_res(ST_INVALID, 0, 0, 0, 0, 1));
        end else if (c.req == REQ_START_ONCE || c.req == REQ_RESTART) begin
          tbl_per[c.slot] = 0;
          tbl_period[c.slot] = c.duration_us;
          tbl_expiry[c.slot] = c.now_us + c.duration_us;
          tbl_active[c.slot] = 1;
          if (c.req == REQ_START_ONCE && c.duration_us == 0) begin
            tbl_active[c.slot] = 0;
            pending_results.push_back(mk_res(ST_OK, c.slot, 1, 0, 1, 1));
          end else begin
            pending_results.push_back(mk_res(ST_OK, 0, 0, 0, 0, 1));
          end
        end else if (c.req == REQ_START_PER) begin
          if (c.duration_us == 0) begin
            pending_results.push_back(mk_res(ST_INVALID, 0, 0, 0, 0, 1));
          end else begin
            tbl_per[c.slot] = 1;
            tbl_period[c.slot] = c.duration_us;
            tbl_expiry[c.slot] = c.now_us + c.duration_us;
            tbl_active[c.slot] = 1;
            pending_results.push_back(mk_res(ST_OK, 0, 0, 0, 0, 1));
          end
        end else if (c.req == REQ_STOP) begin
          tbl_active[c.slot] = 0;
          pending_results.push_back(mk_res(ST_OK, 0, 0, 0, 0, 1));
        end else if (c.req == REQ_DELETE) begin
          tbl_alloc[c.slot] = 0; tbl_active[c.slot] = 0; tbl_per[c.slot] = 0;
          pending_results.push_back(mk_res(ST_OK, 0, 0, 0, 0, 1));
        end else begin
          pending_results.push_back(mk_res(ST_OK, 0, 0, tbl_active[c.slot], 0, 1));
        end
      end
    endcase
  endtask

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 45) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Drive one request and wait for its transfer; valid drops only for a gap.
  task automatic send_request(cmd_t c);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_tvalid <= 0;
      repeat (g) @(negedge clk);
    end
    in_tdata  <= {7'b0, c.fire_cap, c.duration_us, c.now_us, c.slot};
    in_tuser  <= c.req;
    in_tvalid <= 1;
    do @(posedge clk); while (!in_tready);
    predict_timer_request(c);
    @(negedge clk);
  endtask

  function automatic cmd_t mk_cmd(req_t q, logic [3:0] s, logic [63:0] t,
                                  logic [63:0] d, logic [4:0] m);
    cmd_t c;
    c.req = q; c.slot = s; c.now_us = t; c.duration_us = d; c.fire_cap = m;
    return c;
  endfunction

  // Directed rows; a row with a typed-in result checks it against the predictor too.
  typedef struct {
    cmd_t c;
    logic has_exp;
    res_t exp_res;
  } row_t;

  row_t dir_rows[$];
  res_t none_res;

  task automatic add_row(cmd_t c, logic he, res_t e);
    row_t r;
    r.c = c; r.has_exp = he; r.exp_res = e;
    dir_rows.push_back(r);
  endtask

  localparam logic [63:0] TMAX = 64'hFFFF_FFFF_FFFF_FFFF;

  // Clock
  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // Result checking
  always @(posedge clk) begin
    res_t want;
    res_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.status     = status_t'(out_tdata[1:0]);
      got.handle     = out_tdata[5:2];
      got.fired      = out_tuser;
      got.is_running = out_tdata[6];
      got.fire_count = out_tdata[11:7];
      got.last       = out_tlast;
      if (pending_results.size() == 0) begin
        $error("unexpected result transfer %h", out_tdata);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (got.status != want.status) begin
          $error("status exp %0d got %0d", want.status, got.status); errors++;
        end
        if (got.handle != want.handle) begin
          $error("handle exp %0d got %0d", want.handle, got.handle); errors++;
        end
        if (got.fired != want.fired) begin
          $error("fired exp %0d got %0d", want.fired, got.fired); errors++;
        end
        if (got.is_running != want.is_running) begin
          $error("is_running exp %0d got %0d", want.is_running, got.is_running); errors++;
        end
        if (got.fire_count != want.fire_count) begin
          $error("fire_count exp %0d got %0d", want.fire_count, got.fire_count); errors++;
        end
        if (got.last != want.last) begin
          $error("last exp %0d got %0d", want.last, got.last); errors++;
        end
        if (out_tdata[15:12] != 0) begin
          $error("zero fill exp 0 got %0h", out_tdata[15:12]); errors++;
        end
      end
    end
  end

  // Result-side stalls; ready drops only when the gap is not empty.
  initial begin
    int quiet;
    int g;
    out_tready = 0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      quiet = $urandom_range(0, 2) == 0 ? 30 : 0;
      out_tready <= 1;
      repeat ($urandom_range(1, 8) + quiet) @(negedge clk);
      g = gap_len();
      if (g > 0) begin
        out_tready <= 0;
        repeat (g) @(negedge clk);
      end
    end
  end

  // Stimulus
  initial begin
    cmd_t c;
    int   n;
    logic [63:0] base;
    in_tvalid = 0;
    in_tdata  = '0;
    in_tuser  = '0;
    rst_n     = 0;
    foreach (tbl_alloc[i]) begin
      tbl_alloc[i] = 0; tbl_active[i] = 0; tbl_per[i] = 0;
      tbl_period[i] = 0; tbl_expiry[i] = 0;
    end
    none_res = mk_res(ST_OK, 0, 0, 0, 0, 1);
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // Directed part: empty table, extremes, every request and special case.
    add_row(mk_cmd(REQ_POLL, 0, TMAX, 0, 16), 1, none_res);
    add_row(mk_cmd(REQ_STOP, 15, 0, 0, 0), 1, mk_res(ST_INVALID, 0, 0, 0, 0, 1));
    add_row(mk_cmd(REQ_IS_ACTIVE, 3, 0, 0, 0), 1, mk_res(ST_INVALID, 0, 0, 0, 0, 1));
    add_row(mk_cmd(REQ_CREATE, 0, 0, 0, 0), 1, mk_res(ST_OK, 0, 0, 0, 0, 1));
    add_row(mk_cmd(REQ_CREATE, 0, 0, 0, 0), 1, mk_res(ST_OK, 1, 0, 0, 0, 1));
    add_row(mk_cmd(REQ_START_ONCE, 0, 100, 0, 0), 1, mk_res(ST_OK, 0, 1, 0, 1, 1));
    add_row(mk_cmd(REQ_START_PER, 1, 5, 0, 0), 1, mk_res(ST_INVALID, 0, 0, 0, 0, 1));
    add_row(mk_cmd(REQ_START_PER, 1, TMAX, 10, 0), 0, none_res);
    add_row(mk_cmd(REQ_IS_ACTIVE, 1, 0, 0, 0), 1, mk_res(ST_OK, 0, 0, 1, 0, 1));
    add_row(mk_cmd(REQ_POLL, 0, 8, 0, 31), 0, none_res);
    add_row(mk_cmd(REQ_RESTART, 0, TMAX, 0, 0), 0, none_res);
    add_row(mk_cmd(REQ_POLL, 0, TMAX, 0, 0), 1, none_res);
    add_row(mk_cmd(REQ_POLL, 0, TMAX, 0, 1), 0, none_res);
    add_row(mk_cmd(REQ_START_ONCE, 0, 1, TMAX, 0), 0, none_res);
    add_row(mk_cmd(REQ_POLL, 0, 0, 0, 16), 0, none_res);
    add_row(mk_cmd(REQ_STOP, 1, 0, 0, 0), 0, none_res);
    add_row(mk_cmd(REQ_DELETE, 1, 0, 0, 0), 0, none_res);
    add_row(mk_cmd(REQ_IS_ACTIVE, 1, 0, 0, 0), 1, mk_res(ST_INVALID, 0, 0, 0, 0, 1));
    for (int i = 0; i < 15; i++) add_row(mk_cmd(REQ_CREATE, 0, 0, 0, 0), 0, none_res);
    add_row(mk_cmd(REQ_CREATE, 0, 0, 0, 0), 1, mk_res(ST_NO_MEM, 0, 0, 0, 0, 1));
    foreach (dir_rows[k]) begin
      send_request(dir_rows[k].c);
      // Typed-in rows cause one result, which is the newest in the queue.
      if (dir_rows[k].has_exp &&
          pending_results[pending_results.size() - 1] != dir_rows[k].exp_res) begin
        $error("table row %0d: predictor disagrees with typed-in result", k);
        errors++;
      end
    end

    // Random part: mostly start/poll traffic on allocated slots around a
    // moving time base, with some noise requests and raw random fields.
    base = rand64();
    n = 0;
    while (n < 440) begin
      c = mk_cmd(req_t'($urandom_range(0, 7)), 4'($urandom_range(0, 15)),
                 base + 64'($urandom_range(0, 200)), 64'($urandom_range(0, 150)),
                 5'($urandom_range(0, 31)));
      case ($urandom_range(0, 9))
        0: begin
          c.now_us = rand64(); c.duration_us = rand64();
        end
        1: c.duration_us = 0;
        2, 3: c.req = REQ_POLL;
        4: c.req = ($urandom_range(0, 1) == 1) ? REQ_START_PER : REQ_START_ONCE;
        5: if ($urandom_range(0, 3) == 0) c.now_us = TMAX - 64'($urandom_range(0, 100));
        default: ;
      endcase
      if ($urandom_range(0, 4) == 0) base = base + 64'($urandom_range(0, 120));
      send_request(c);
      n++;
    end
    in_tvalid <= 0;
    done_sending = 1;
  end

  // End of run
  initial begin
    wait (done_sending);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Timeout
  initial begin
    #20ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule
